>>> hw/rtl/rf_wakeup_energy_detector_macros.svh
// Assertion macros shared by the wake-up energy detector RTL.
// Both macros sample on the rising clock and are disabled while reset is low.
`ifndef RF_WAKEUP_ENERGY_DETECTOR_MACROS_SVH
`define RF_WAKEUP_ENERGY_DETECTOR_MACROS_SVH

// Same-cycle implication.
`define RFWED_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RFWED_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rfwed_pkg.sv
// Package for the wake-up energy detector: operation codes, register indexes,
// fixed field widths and register reset values. No dependencies.
`default_nettype none

package rfwed_pkg;

    typedef enum logic
    {
        OP_REFERENCE = 1'b0,
        OP_SAMPLE    = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        REG_CUTOFF_SCALE   = 3'd0,
        REG_SHORT_COUNT    = 3'd1,
        REG_SHORT_MAX_FAIL = 3'd2,
        REG_TOTAL_COUNT    = 3'd3,
        REG_LONG_MAX_FAIL  = 3'd4
    } reg_index_t;

    localparam int SCALE_BITS  = 5;
    localparam int FAIL_BITS   = 7;
    localparam int SCALE_SHIFT = 5;
    localparam int ADDR_BITS   = 5;
    localparam int DATA_BITS   = 32;

    localparam int CUTOFF_SCALE_RESET   = 4;
    localparam int SHORT_COUNT_RESET    = 10;
    localparam int SHORT_MAX_FAIL_RESET = 2;
    localparam int TOTAL_COUNT_RESET    = 85;
    localparam int LONG_MAX_FAIL_RESET  = 15;

endpackage

`default_nettype wire

>>> hw/rtl/rfwed_cfg.sv
// Configuration register file of the wake-up energy detector, APB-style port.
// Depends on rfwed_pkg.
`default_nettype none

module rfwed_cfg
    import rfwed_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_BITS-1:0]  paddr,
    input  wire logic [DATA_BITS-1:0]  pwdata,
    output logic      [DATA_BITS-1:0]  prdata,
    output logic                       pready,
    output logic      [SCALE_BITS-1:0] cutoff_scale,
    output logic      [COUNT_BITS-1:0] short_count,
    output logic      [FAIL_BITS-1:0]  short_max_fail,
    output logic      [COUNT_BITS-1:0] total_count,
    output logic      [FAIL_BITS-1:0]  long_max_fail
);

    logic [SCALE_BITS-1:0] cutoff_scale_reg;
    logic [COUNT_BITS-1:0] short_count_reg;
    logic [FAIL_BITS-1:0]  short_max_fail_reg;
    logic [COUNT_BITS-1:0] total_count_reg;
    logic [FAIL_BITS-1:0]  long_max_fail_reg;
    reg_index_t            reg_index;
    logic                  write_en;

    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[ADDR_BITS-1:2]);
    assign write_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_scale_reg   <= SCALE_BITS'(CUTOFF_SCALE_RESET);
            short_count_reg    <= COUNT_BITS'(SHORT_COUNT_RESET);
            short_max_fail_reg <= FAIL_BITS'(SHORT_MAX_FAIL_RESET);
            total_count_reg    <= COUNT_BITS'(TOTAL_COUNT_RESET);
            long_max_fail_reg  <= FAIL_BITS'(LONG_MAX_FAIL_RESET);
        end
        else if (write_en)
        begin
            case (reg_index)
                REG_CUTOFF_SCALE:   cutoff_scale_reg   <= pwdata[SCALE_BITS-1:0];
                REG_SHORT_COUNT:    short_count_reg    <= pwdata[COUNT_BITS-1:0];
                REG_SHORT_MAX_FAIL: short_max_fail_reg <= pwdata[FAIL_BITS-1:0];
                REG_TOTAL_COUNT:    total_count_reg    <= pwdata[COUNT_BITS-1:0];
                REG_LONG_MAX_FAIL:  long_max_fail_reg  <= pwdata[FAIL_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_CUTOFF_SCALE:   prdata = DATA_BITS'(cutoff_scale_reg);
            REG_SHORT_COUNT:    prdata = DATA_BITS'(short_count_reg);
            REG_SHORT_MAX_FAIL: prdata = DATA_BITS'(short_max_fail_reg);
            REG_TOTAL_COUNT:    prdata = DATA_BITS'(total_count_reg);
            REG_LONG_MAX_FAIL:  prdata = DATA_BITS'(long_max_fail_reg);
            default:            prdata = '0;
        endcase
    end

    assign cutoff_scale   = cutoff_scale_reg;
    assign short_count    = short_count_reg;
    assign short_max_fail = short_max_fail_reg;
    assign total_count    = total_count_reg;
    assign long_max_fail  = long_max_fail_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rf_wakeup_energy_detector.sv
// Top level of the wake-up energy detector: input stage, round logic and result register.
// Depends on rfwed_pkg, rfwed_cfg and rf_wakeup_energy_detector_macros.svh.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+---------------------------------------------
//   in      | in_valid / in_stall       | operation, sample_value
//   out     | out_valid / out_stall     | wake, samples_used, short_failures,
//           |                           | long_failures
//   cfg     | psel, penable, pwrite     | paddr, pwdata, prdata (pready tied high)
//
// An item is held in the input register, where the round logic works on it, and its
// result is then loaded into the result register; one item is taken per cycle unless a
// stalled result holds an item that would produce another result. The combinational
// compare and counter update on the round state set that rate.
// Reset is asynchronous and active low; it drops any running round without a result.
// A stalled result blocks only items that would produce another result.
`default_nettype none

`include "rf_wakeup_energy_detector_macros.svh"

module rf_wakeup_energy_detector
    import rfwed_pkg::*;
#(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   operation,
    input  wire logic [SAMPLE_BITS-1:0] sample_value,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        wake,
    output logic      [COUNT_BITS-1:0]  samples_used,
    output logic      [FAIL_BITS-1:0]   short_failures,
    output logic      [FAIL_BITS-1:0]   long_failures,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_BITS-1:0]   paddr,
    input  wire logic [DATA_BITS-1:0]   pwdata,
    output logic      [DATA_BITS-1:0]   prdata,
    output logic                        pready
);

    localparam int CUT_W    = SAMPLE_BITS + 2;
    localparam int LEVEL_W  = SAMPLE_BITS + 1;
    localparam int HALF_W   = SAMPLE_BITS - 1;
    localparam int SCALED_W = SCALE_BITS + HALF_W;

    logic [SCALE_BITS-1:0] cutoff_scale;
    logic [COUNT_BITS-1:0] short_count;
    logic [FAIL_BITS-1:0]  short_max_fail;
    logic [COUNT_BITS-1:0] total_count;
    logic [FAIL_BITS-1:0]  long_max_fail;

    logic                   in_valid_reg;
    op_t                    op_reg;
    logic [SAMPLE_BITS-1:0] value_reg;

    logic [CUT_W-1:0]      cutoff_reg;
    logic [COUNT_BITS-1:0] index_reg;
    logic [FAIL_BITS-1:0]  short_fails_reg;
    logic [FAIL_BITS-1:0]  long_fails_reg;
    logic                  active_reg;

    logic [CUT_W-1:0]      cutoff_next;
    logic [COUNT_BITS-1:0] index_next;
    logic [FAIL_BITS-1:0]  short_fails_next;
    logic [FAIL_BITS-1:0]  long_fails_next;
    logic                  active_next;
    logic                  emit;
    logic                  wake_next;

    logic                  out_valid_reg;
    logic                  wake_reg;
    logic [COUNT_BITS-1:0] samples_used_reg;
    logic [FAIL_BITS-1:0]  short_failures_reg;
    logic [FAIL_BITS-1:0]  long_failures_reg;

    logic                  in_accept;
    logic                  advance;
    logic                  result_load;
    logic [SCALED_W-1:0]   scaled;
    logic [LEVEL_W-1:0]    level;
    logic [CUT_W-1:0]      cutoff_calc;
    logic                  sample_fail;

    rfwed_cfg #(
        .COUNT_BITS (COUNT_BITS)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .cutoff_scale   (cutoff_scale),
        .short_count    (short_count),
        .short_max_fail (short_max_fail),
        .total_count    (total_count),
        .long_max_fail  (long_max_fail)
    );

    function automatic logic may_continue(
        input logic [COUNT_BITS-1:0] idx,
        input logic [FAIL_BITS-1:0]  f_short,
        input logic [FAIL_BITS-1:0]  f_long,
        input logic [COUNT_BITS-1:0] s_count,
        input logic [COUNT_BITS-1:0] t_count,
        input logic [FAIL_BITS-1:0]  s_max,
        input logic [FAIL_BITS-1:0]  l_max
    );
        return (f_short < s_max) && ((idx < s_count) || ((idx < t_count) && (f_long < l_max)));
    endfunction

    // The cutoff is full scale minus the sum of the reference and its scaled lower half.
    assign scaled      = SCALED_W'(cutoff_scale) * SCALED_W'(value_reg[HALF_W-1:0]);
    assign level       = LEVEL_W'(value_reg) + LEVEL_W'(scaled >> SCALE_SHIFT);
    assign cutoff_calc = CUT_W'({SAMPLE_BITS{1'b1}}) - CUT_W'(level);
    assign sample_fail = $signed({2'b00, value_reg}) < $signed(cutoff_reg);

    always_comb
    begin
        cutoff_next      = cutoff_reg;
        index_next       = index_reg;
        short_fails_next = short_fails_reg;
        long_fails_next  = long_fails_reg;
        active_next      = active_reg;
        emit             = 1'b0;
        case (op_reg)
            OP_REFERENCE:
            begin
                cutoff_next      = cutoff_calc;
                index_next       = '0;
                short_fails_next = '0;
                long_fails_next  = '0;
                active_next      = 1'b1;
            end
            OP_SAMPLE:
            begin
                if (active_reg && may_continue(index_reg, short_fails_reg, long_fails_reg,
                                               short_count, total_count,
                                               short_max_fail, long_max_fail))
                begin
                    if (index_reg < short_count)
                    begin
                        short_fails_next = short_fails_reg + FAIL_BITS'(sample_fail);
                    end
                    else
                    begin
                        long_fails_next = long_fails_reg + FAIL_BITS'(sample_fail);
                    end
                    index_next = index_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (active_next && !may_continue(index_next, short_fails_next, long_fails_next,
                                         short_count, total_count,
                                         short_max_fail, long_max_fail))
        begin
            emit        = 1'b1;
            active_next = 1'b0;
        end
        wake_next = (short_fails_next < short_max_fail) && (long_fails_next < long_max_fail);
    end

    assign in_accept   = in_valid && !in_stall;
    assign advance     = in_valid_reg && (!out_valid_reg || !out_stall || !emit);
    assign result_load = advance && emit;
    assign in_stall    = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= op_t'(operation);
            value_reg <= sample_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg      <= '0;
            index_reg       <= '0;
            short_fails_reg <= '0;
            long_fails_reg  <= '0;
            active_reg      <= 1'b0;
        end
        else if (advance)
        begin
            cutoff_reg      <= cutoff_next;
            index_reg       <= index_next;
            short_fails_reg <= short_fails_next;
            long_fails_reg  <= long_fails_next;
            active_reg      <= active_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            wake_reg           <= wake_next;
            samples_used_reg   <= index_next;
            short_failures_reg <= short_fails_next;
            long_failures_reg  <= long_fails_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign wake           = wake_reg;
    assign samples_used   = samples_used_reg;
    assign short_failures = short_failures_reg;
    assign long_failures  = long_failures_reg;

    `RFWED_ASSERT_NXT(a_round_closed_after_result, clk, rst_n, result_load, !active_reg,
        "round still active after its result was loaded")
    `RFWED_ASSERT_IMP(a_index_steps_by_one, clk, rst_n, index_reg != $past(index_reg),
        index_reg == '0 || index_reg == $past(index_reg) + 1'b1,
        "sample index moved by more than one")
    `RFWED_ASSERT_IMP(a_no_stall_when_empty, clk, rst_n, !in_valid_reg, !in_stall,
        "input stalled with an empty input stage")

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for rf_wakeup_energy_detector: directed and random rounds
// on the sample channel, register writes over the APB port, and a scoreboard fed by
// an in-bench model of the round logic. Depends on rfwed_pkg and the detector RTL.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rfwed_pkg::*;

    localparam int SAMPLE_BITS  = 10;
    localparam int COUNT_BITS   = 16;
    localparam int FULL_SCALE   = (1 << SAMPLE_BITS) - 1;
    localparam int HALF_MASK    = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int DRAIN_CYCLES = 6;
    localparam int SETTLE_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 2000;

    typedef struct packed
    {
        logic                  wake;
        logic [COUNT_BITS-1:0] used;
        logic [FAIL_BITS-1:0]  short_fails;
        logic [FAIL_BITS-1:0]  long_fails;
    } round_report_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   operation = 1'b0;
    logic [SAMPLE_BITS-1:0] sample_value = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   wake;
    logic [COUNT_BITS-1:0]  samples_used;
    logic [FAIL_BITS-1:0]   short_failures;
    logic [FAIL_BITS-1:0]   long_failures;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_BITS-1:0]   paddr = '0;
    logic [DATA_BITS-1:0]   pwdata = '0;
    logic [DATA_BITS-1:0]   prdata;
    logic                   pready;

    int unsigned cfg_scale       = CUTOFF_SCALE_RESET;
    int unsigned cfg_short_count = SHORT_COUNT_RESET;
    int unsigned cfg_short_max   = SHORT_MAX_FAIL_RESET;
    int unsigned cfg_total_count = TOTAL_COUNT_RESET;
    int unsigned cfg_long_max    = LONG_MAX_FAIL_RESET;

    int          cutoff_lvl = 0;
    int unsigned samp_idx = 0;
    int unsigned short_fails = 0;
    int unsigned long_fails = 0;
    bit          round_open = 1'b0;

    round_report_t due_reports[$];
    int unsigned   items_done = 0;
    int unsigned   error_count = 0;
    int            gap_pct = 23;
    int            stall_pct = 23;

    rf_wakeup_energy_detector dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .sample_value(sample_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .wake(wake),
        .samples_used(samples_used),
        .short_failures(short_failures),
        .long_failures(long_failures),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic bit round_may_go();
        if (short_fails >= cfg_short_max)
            return 1'b0;
        if (samp_idx < cfg_short_count)
            return 1'b1;
        return samp_idx < cfg_total_count && long_fails < cfg_long_max;
    endfunction

    function automatic void close_round();
        round_report_t r;
        r.wake        = short_fails < cfg_short_max && long_fails < cfg_long_max;
        r.used        = COUNT_BITS'(samp_idx);
        r.short_fails = FAIL_BITS'(short_fails);
        r.long_fails  = FAIL_BITS'(long_fails);
        due_reports.push_back(r);
        round_open = 1'b0;
    endfunction

    function automatic void advance_round(op_t op, logic [SAMPLE_BITS-1:0] value);
        int unsigned level;
        if (op == OP_REFERENCE)
        begin
            level = value + ((cfg_scale * (value & HALF_MASK)) >> SCALE_SHIFT);
            cutoff_lvl = FULL_SCALE - int'(level);
            samp_idx = 0;
            short_fails = 0;
            long_fails = 0;
            round_open = 1'b1;
            if (!round_may_go())
                close_round();
        end
        else if (round_open)
        begin
            if (round_may_go())
            begin
                if (int'(value) < cutoff_lvl)
                begin
                    if (samp_idx < cfg_short_count)
                        short_fails++;
                    else
                        long_fails++;
                end
                samp_idx++;
            end
            if (!round_may_go())
                close_round();
        end
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] near_cutoff(int unsigned fail_pct);
        int v;
        if ($urandom_range(9) == 0)
            return SAMPLE_BITS'($urandom_range(FULL_SCALE));
        if ($urandom_range(99) < fail_pct)
            v = cutoff_lvl - 1 - int'($urandom_range(24));
        else
            v = cutoff_lvl + int'($urandom_range(24));
        if (v < 0)
            v = 0;
        if (v > FULL_SCALE)
            v = FULL_SCALE;
        return SAMPLE_BITS'(v);
    endfunction

    function automatic int unsigned pick_value(int unsigned lo, int unsigned hi,
                                               int unsigned typical);
        int unsigned k;
        k = $urandom_range(99);
        if (k < 8)
            return lo;
        if (k < 16)
            return hi;
        return typical;
    endfunction

    task automatic send_item(op_t op, logic [SAMPLE_BITS-1:0] value);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        sample_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_done++;
        advance_round(op, value);
    endtask

    // Returns once every predicted report has been taken or SETTLE_LIMIT is reached, and
    // any item that produces no report has had time to leave the pipeline.
    task automatic settle();
        int spins;
        spins = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_reports.size() != 0 && spins < SETTLE_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_BITS'(4 * int'(idx));
        pwdata <= DATA_BITS'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CUTOFF_SCALE:   cfg_scale = value;
            REG_SHORT_COUNT:    cfg_short_count = value;
            REG_SHORT_MAX_FAIL: cfg_short_max = value;
            REG_TOTAL_COUNT:    cfg_total_count = value;
            REG_LONG_MAX_FAIL:  cfg_long_max = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic test_idle_samples();
        send_item(OP_SAMPLE, SAMPLE_BITS'(FULL_SCALE));
        send_item(OP_SAMPLE, '0);
    endtask

    task automatic test_instant_rounds();
        settle();
        write_reg(REG_SHORT_MAX_FAIL, 0);
        send_item(OP_REFERENCE, SAMPLE_BITS'(512));
        settle();
        write_reg(REG_SHORT_MAX_FAIL, 1);
        write_reg(REG_SHORT_COUNT, 0);
        write_reg(REG_TOTAL_COUNT, 0);
        send_item(OP_REFERENCE, '0);
        settle();
        write_reg(REG_TOTAL_COUNT, 5);
        write_reg(REG_LONG_MAX_FAIL, 0);
        send_item(OP_REFERENCE, SAMPLE_BITS'(FULL_SCALE));
    endtask

    task automatic test_extreme_settings();
        settle();
        write_reg(REG_CUTOFF_SCALE, 31);
        write_reg(REG_SHORT_COUNT, 65535);
        write_reg(REG_TOTAL_COUNT, 65535);
        write_reg(REG_SHORT_MAX_FAIL, 1);
        write_reg(REG_LONG_MAX_FAIL, 127);
        send_item(OP_REFERENCE, SAMPLE_BITS'(FULL_SCALE));
        send_item(OP_SAMPLE, '0);
        send_item(OP_REFERENCE, '0);
        send_item(OP_SAMPLE, SAMPLE_BITS'(FULL_SCALE));
        send_item(OP_SAMPLE, '0);
    endtask

    task automatic test_phase_limits();
        settle();
        write_reg(REG_CUTOFF_SCALE, 0);
        write_reg(REG_SHORT_COUNT, 2);
        write_reg(REG_TOTAL_COUNT, 6);
        write_reg(REG_SHORT_MAX_FAIL, 127);
        write_reg(REG_LONG_MAX_FAIL, 2);
        send_item(OP_REFERENCE, '0);
        send_item(OP_SAMPLE, SAMPLE_BITS'(FULL_SCALE));
        repeat (3) send_item(OP_SAMPLE, '0);
    endtask

    task automatic test_midround_change();
        settle();
        write_reg(REG_CUTOFF_SCALE, 8);
        write_reg(REG_SHORT_COUNT, 4);
        write_reg(REG_TOTAL_COUNT, 8);
        write_reg(REG_SHORT_MAX_FAIL, 3);
        write_reg(REG_LONG_MAX_FAIL, 3);
        send_item(OP_REFERENCE, SAMPLE_BITS'(600));
        send_item(OP_SAMPLE, SAMPLE_BITS'(600));
        send_item(OP_SAMPLE, SAMPLE_BITS'(300));
        settle();
        write_reg(REG_SHORT_COUNT, 1);
        write_reg(REG_TOTAL_COUNT, 1);
        send_item(OP_SAMPLE, SAMPLE_BITS'(100));
    endtask

    task automatic test_random_rounds();
        int unsigned phase;
        int unsigned item_start;
        int unsigned phase_end;
        int unsigned span;
        int unsigned len;
        int unsigned fail_pct;
        int unsigned k;
        logic [SAMPLE_BITS-1:0] ref_val;
        phase = 0;
        item_start = items_done;
        while (items_done - item_start < RANDOM_ITEMS)
        begin
            phase++;
            settle();
            write_reg(REG_CUTOFF_SCALE, pick_value(0, 31, $urandom_range(31)));
            write_reg(REG_SHORT_COUNT, pick_value(0, 65535, $urandom_range(24, 1)));
            write_reg(REG_TOTAL_COUNT, pick_value(0, 65535, $urandom_range(48)));
            write_reg(REG_SHORT_MAX_FAIL, pick_value(0, 127, $urandom_range(6, 1)));
            write_reg(REG_LONG_MAX_FAIL, pick_value(0, 127, $urandom_range(10, 1)));
            if (phase == 4)
            begin
                gap_pct = 0;
                stall_pct = 0;
                phase_end = items_done + 400;
            end
            else
            begin
                gap_pct = 23;
                stall_pct = 23;
                phase_end = items_done + $urandom_range(160, 40);
            end
            while (items_done < phase_end)
            begin
                if ($urandom_range(99) < 8)
                begin
                    send_item(op_t'($urandom_range(1)), SAMPLE_BITS'($urandom_range(FULL_SCALE)));
                end
                else
                begin
                    k = $urandom_range(99);
                    if (k < 15)
                        ref_val = '0;
                    else if (k < 30)
                        ref_val = SAMPLE_BITS'(FULL_SCALE);
                    else
                        ref_val = SAMPLE_BITS'($urandom_range(FULL_SCALE));
                    send_item(OP_REFERENCE, ref_val);
                    span = (cfg_short_count > cfg_total_count) ? cfg_short_count
                                                               : cfg_total_count;
                    if (span > 48)
                        span = 48;
                    len = $urandom_range(span + 3);
                    fail_pct = $urandom_range(100);
                    repeat (len) send_item(OP_SAMPLE, near_cutoff(fail_pct));
                end
            end
        end
        gap_pct = 23;
        stall_pct = 23;
    endtask

    initial
    begin : report_check
        round_report_t got;
        round_report_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.wake = wake;
                got.used = samples_used;
                got.short_fails = short_failures;
                got.long_fails = long_failures;
                if (due_reports.size() == 0)
                begin
                    note_error($sformatf("unexpected report: wake=%0d used=%0d short=%0d long=%0d",
                                         got.wake, got.used, got.short_fails, got.long_fails));
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (got.wake !== want.wake || got.used !== want.used ||
                        got.short_fails !== want.short_fails ||
                        got.long_fails !== want.long_fails)
                        note_error($sformatf({"report mismatch: expected wake=%0d used=%0d ",
                                              "short=%0d long=%0d, got wake=%0d used=%0d ",
                                              "short=%0d long=%0d"},
                                             want.wake, want.used, want.short_fails,
                                             want.long_fails, got.wake, got.used,
                                             got.short_fails, got.long_fails));
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_samples();
        test_instant_rounds();
        test_extreme_settings();
        test_phase_limits();
        test_midround_change();
        test_random_rounds();
        settle();
        if (due_reports.size() != 0)
            note_error($sformatf("%0d expected reports never arrived", due_reports.size()));
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
